// File: src/b64lw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64lw_pkg
// shared types, constants and the base64 symbol lookup for the line-wrapping
// encoder
// ----------------------------------------------------------------------------
package b64lw_pkg;

	localparam int BYTE_W = 8;
	localparam int GPL_W  = 6;
	localparam int SIX_W  = 6;
	localparam int STEP_W = 3;

	localparam logic [GPL_W-1:0] GPL_RESET = 6'd16;

	localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;
	localparam logic [BYTE_W-1:0] PAD_CHAR  = 8'h3D;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// character slots of one group command
	localparam logic [STEP_W-1:0] STEP_LF_BEFORE = 3'd0;
	localparam logic [STEP_W-1:0] STEP_SYM0      = 3'd1;
	localparam logic [STEP_W-1:0] STEP_SYM1      = 3'd2;
	localparam logic [STEP_W-1:0] STEP_SYM2      = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SYM3      = 3'd4;
	localparam logic [STEP_W-1:0] STEP_LF_AFTER  = 3'd5;

	// bytes carried by a group
	typedef enum logic [1:0] {
		TAKEN_ONE   = 2'd1,
		TAKEN_TWO   = 2'd2,
		TAKEN_THREE = 2'd3
	} taken_t;

	// one group to be written out by the back end
	typedef struct packed {
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] y;
		logic [BYTE_W-1:0] z;
		taken_t            taken;
		logic              lf_before;
		logic              lf_after;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	// six-bit value to base64 alphabet character
	function automatic logic [BYTE_W-1:0] sym(input logic [SIX_W-1:0] v);
		logic [BYTE_W-1:0] r;
		if (v < 6'd26) begin
			r = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'd71 + {2'b00, v};
		end else if (v < 6'd62) begin
			r = {2'b00, v} - 8'd4;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/b64lw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64lw_front
// collects bytes into groups, tracks line fill and queues group commands
// ----------------------------------------------------------------------------
module b64lw_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [b64lw_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                          final_byte,
	input  wire logic                          cfg_valid,
	input  wire logic [b64lw_pkg::GPL_W-1:0]   cfg_data,
	input  wire b64lw_pkg::q_status_t          q_status,
	output logic                               enq,
	output b64lw_pkg::cmd_t                    enq_cmd
);

	logic [b64lw_pkg::BYTE_W-1:0] first_q;
	logic [b64lw_pkg::BYTE_W-1:0] second_q;
	logic [1:0]                   gpos_q;
	logic [b64lw_pkg::GPL_W-1:0]  line_groups_q;
	logic [b64lw_pkg::GPL_W-1:0]  gpl_q;
	logic [b64lw_pkg::GPL_W-1:0]  limit;
	logic                         accept;
	logic                         holding;

	assign accept  = push && !q_status.full;
	assign holding = !final_byte && (gpos_q != 2'd2);
	assign limit   = (gpl_q == '0) ? 6'd1 : gpl_q;
	assign enq     = accept && !holding;

	always_comb begin
		enq_cmd.taken     = b64lw_pkg::taken_t'(gpos_q + 2'd1);
		enq_cmd.lf_before = (line_groups_q >= limit);
		enq_cmd.lf_after  = final_byte;
		case (gpos_q)
			2'd0: begin
				enq_cmd.x = data_byte;
				enq_cmd.y = '0;
				enq_cmd.z = '0;
			end
			2'd1: begin
				enq_cmd.x = first_q;
				enq_cmd.y = data_byte;
				enq_cmd.z = '0;
			end
			default: begin
				enq_cmd.x = first_q;
				enq_cmd.y = second_q;
				enq_cmd.z = data_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpos_q        <= '0;
			line_groups_q <= '0;
			gpl_q         <= b64lw_pkg::GPL_RESET;
		end else begin
			if (cfg_valid) begin
				gpl_q <= cfg_data;
			end
			if (accept) begin
				if (holding) begin
					gpos_q <= gpos_q + 2'd1;
				end else begin
					gpos_q <= '0;
					if (final_byte) begin
						line_groups_q <= '0;
					end else if (enq_cmd.lf_before) begin
						line_groups_q <= 6'd1;
					end else begin
						line_groups_q <= line_groups_q + 6'd1;
					end
				end
			end
		end
	end

	// pending bytes, no reset needed
	always_ff @(posedge clk) begin
		if (accept && holding) begin
			if (gpos_q == 2'd0) begin
				first_q <= data_byte;
			end else begin
				second_q <= data_byte;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/b64lw_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64lw_cmdq
// small command queue between the front and back ends
// ----------------------------------------------------------------------------
module b64lw_cmdq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              enq,
	input  wire b64lw_pkg::cmd_t   enq_cmd,
	input  wire logic              deq,
	output b64lw_pkg::cmd_t        head,
	output b64lw_pkg::q_status_t   status
);

	b64lw_pkg::cmd_t                  entries_q [b64lw_pkg::QUEUE_DEPTH];
	logic [b64lw_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [b64lw_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [b64lw_pkg::QCNT_W-1:0]     count_q;

	assign status.full      = (count_q == b64lw_pkg::QCNT_W'(b64lw_pkg::QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);
	assign head             = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			entries_q[wr_ptr_q] <= enq_cmd;
		end
	end

endmodule
`default_nettype wire

// File: src/b64lw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64lw_back
// walks a group command a character per cycle into char_q when empty or popped
// ----------------------------------------------------------------------------
module b64lw_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire b64lw_pkg::cmd_t              head,
	input  wire b64lw_pkg::q_status_t         q_status,
	output logic                              deq,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [b64lw_pkg::BYTE_W-1:0]      out_char,
	output logic                              last_of_run
);

	b64lw_pkg::cmd_t              cmd_q;
	logic                         busy_q;
	logic [b64lw_pkg::STEP_W-1:0] step_q;
	logic                         ov_q;
	logic [b64lw_pkg::BYTE_W-1:0] char_q;
	logic                         last_q;

	logic                         can_emit;
	logic                         emit;
	logic                         at_end;
	logic [b64lw_pkg::STEP_W-1:0] end_step;
	logic [b64lw_pkg::STEP_W-1:0] head_start;
	logic [b64lw_pkg::BYTE_W-1:0] cur_char;

	assign can_emit   = !ov_q || pop;
	assign emit       = busy_q && can_emit;
	assign end_step   = cmd_q.lf_after ? b64lw_pkg::STEP_LF_AFTER : b64lw_pkg::STEP_SYM3;
	assign at_end     = (step_q == end_step);
	assign head_start = head.lf_before ? b64lw_pkg::STEP_LF_BEFORE : b64lw_pkg::STEP_SYM0;
	assign deq        = q_status.not_empty && (!busy_q || (emit && at_end));

	assign empty       = !ov_q;
	assign out_char    = char_q;
	assign last_of_run = last_q;

	always_comb begin
		case (step_q)
			b64lw_pkg::STEP_SYM0: cur_char = b64lw_pkg::sym(cmd_q.x[7:2]);
			b64lw_pkg::STEP_SYM1: cur_char = b64lw_pkg::sym({cmd_q.x[1:0], cmd_q.y[7:4]});
			b64lw_pkg::STEP_SYM2: begin
				cur_char = (cmd_q.taken == b64lw_pkg::TAKEN_ONE) ? b64lw_pkg::PAD_CHAR
					: b64lw_pkg::sym({cmd_q.y[3:0], cmd_q.z[7:6]});
			end
			b64lw_pkg::STEP_SYM3: begin
				cur_char = (cmd_q.taken == b64lw_pkg::TAKEN_THREE)
					? b64lw_pkg::sym(cmd_q.z[5:0]) : b64lw_pkg::PAD_CHAR;
			end
			default: cur_char = b64lw_pkg::LINE_FEED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			if (deq) begin
				busy_q <= 1'b1;
				step_q <= head_start;
			end else if (emit) begin
				if (at_end) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (deq) begin
			cmd_q <= head;
		end
		if (emit) begin
			char_q <= cur_char;
			last_q <= at_end;
		end
	end

endmodule
`default_nettype wire

// File: src/base64_line_wrapping_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_line_wrapping_encoder
// base64 encoder with fixed-width line wrapping and padded final flush
// ----------------------------------------------------------------------------
// path: a byte that closes a group goes through the command queue and the back
//   end's command register before its first character is registered
// throughput: one byte per cycle in unless full, one character per cycle out
//   if empty or popped; the back end's character walk sets the sustained rate
// reset: arst_n clears all control state, line count and held-byte count;
//   groups_per_line returns to 16
module base64_line_wrapping_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input, queue style
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	// character output, queue style
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_char,
	output logic             last_of_run,
	// groups_per_line write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data
);

	b64lw_pkg::q_status_t q_status;
	b64lw_pkg::cmd_t      enq_cmd;
	b64lw_pkg::cmd_t      head;
	logic                 enq;
	logic                 deq;

	// register writes land at once, the block is idle by contract
	assign cfg_ready = 1'b1;

	// input stalls only when the command queue is full
	assign full = q_status.full;

	// front end: groups bytes, decides line feeds, one command per group
	b64lw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.enq        (enq),
		.enq_cmd    (enq_cmd)
	);

	// decoupling queue, lets the front keep taking bytes while characters drain
	b64lw_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_cmd (enq_cmd),
		.deq     (deq),
		.head    (head),
		.status  (q_status)
	);

	// back end: leading line feed, four symbols or pads, trailing line feed
	b64lw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.deq         (deq),
		.pop         (pop),
		.empty       (empty),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire
